@@ sv/rocket_flight_phase_detector_unit_assert.svh @@
// Assertion macros used by the checker file of the flight phase detector.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ROCKET_FLIGHT_PHASE_DETECTOR_UNIT_ASSERT_SVH
`define ROCKET_FLIGHT_PHASE_DETECTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rfpd_pkg.sv @@
// Shared constants for the rocket flight phase detector: phase codes,
// configuration register indexes and their reset values. No dependencies.
package rfpd_pkg;

    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 4;

    typedef logic [PHASE_W-1:0]    phase_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    localparam phase_t PHASE_PAD     = 3'd0;
    localparam phase_t PHASE_ASCENT  = 3'd1;
    localparam phase_t PHASE_APOGEE  = 3'd2;
    localparam phase_t PHASE_DESCENT = 3'd3;
    localparam phase_t PHASE_PAYLOAD = 3'd4;
    localparam phase_t PHASE_PROBE   = 3'd5;
    localparam phase_t PHASE_LANDED  = 3'd6;

    localparam cfg_idx_t CFG_DROP_MARGIN   = 2'd0;
    localparam cfg_idx_t CFG_CONFIRM_COUNT = 2'd1;
    localparam cfg_idx_t CFG_PROBE_ALT     = 2'd2;

    localparam cfg_data_t DROP_MARGIN_RST   = 16'd16;
    localparam cnt_t      CONFIRM_COUNT_RST = 4'd3;
    localparam cfg_data_t PROBE_ALT_RST     = 16'd32;
    localparam cnt_t      CNT_MAX           = 4'd15;

endpackage

@@ sv/rocket_flight_phase_detector_unit.sv @@
// An accepted sample is held in the input register, then its result in the
// result register. Throughput: one sample per cycle while out_ready is high;
// each holds one item, so a stalled result still lets one new sample in.
// Reset: asynchronous, active low; window, maximum, apogee, drop counter and
// phase clear to zero, configuration registers return to their defaults.
// Top level of the flight phase detector; depends on rfpd_pkg.
module rocket_flight_phase_detector_unit #(
    parameter int ALT_WIDTH = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [ALT_WIDTH-1:0] altitude,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rfpd_pkg::phase_t            phase,
    output logic signed [ALT_WIDTH-1:0] apogee_altitude,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  rfpd_pkg::cfg_idx_t          cfg_index,
    input  rfpd_pkg::cfg_data_t         cfg_data
);

    localparam int EW = ALT_WIDTH + 4;

    logic                        in_valid_reg;
    logic signed [ALT_WIDTH-1:0] in_alt_reg;
    logic                        out_valid_reg;
    logic signed [ALT_WIDTH-1:0] win_old_reg;
    logic signed [ALT_WIDTH-1:0] win_mid_reg;
    logic signed [ALT_WIDTH-1:0] max_reg;
    logic signed [ALT_WIDTH-1:0] apogee_reg;
    rfpd_pkg::cnt_t              drop_cnt_reg;
    rfpd_pkg::phase_t            phase_reg;
    rfpd_pkg::cfg_data_t         drop_margin_reg;
    rfpd_pkg::cnt_t              confirm_reg;
    rfpd_pkg::cfg_data_t         probe_alt_reg;

    logic signed [ALT_WIDTH-1:0] max_next;
    logic signed [ALT_WIDTH-1:0] apogee_next;
    rfpd_pkg::cnt_t              drop_cnt_next;
    rfpd_pkg::phase_t            phase_next;
    rfpd_pkg::cnt_t              need;
    logic signed [EW-1:0]        newest_x;
    logic signed [EW-1:0]        thresh_x;
    logic signed [EW-1:0]        newest5_x;
    logic signed [EW-1:0]        apogee4_x;
    logic signed [EW-1:0]        probe_x;
    logic                        advance;
    logic                        dropped;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid       = out_valid_reg;
    assign phase           = phase_reg;
    assign apogee_altitude = apogee_reg;

    always_comb
    begin
        max_next  = (in_alt_reg > max_reg) ? in_alt_reg : max_reg;
        newest_x  = EW'(in_alt_reg);
        thresh_x  = EW'(max_next)
                    - $signed({{(EW-rfpd_pkg::CFG_DATA_W){1'b0}}, drop_margin_reg});
        dropped   = newest_x < thresh_x;
        newest5_x = (newest_x <<< 2) + newest_x;
        apogee4_x = EW'(apogee_reg) <<< 2;
        probe_x   = $signed({{(EW-rfpd_pkg::CFG_DATA_W){1'b0}}, probe_alt_reg});
        need      = (confirm_reg == '0) ? rfpd_pkg::cnt_t'(1) : confirm_reg;

        phase_next    = phase_reg;
        apogee_next   = apogee_reg;
        drop_cnt_next = drop_cnt_reg;

        case (phase_reg)
            rfpd_pkg::PHASE_PAD:
            begin
                if ((win_mid_reg < win_old_reg ? 1'b0 : win_old_reg != win_mid_reg)
                    && (win_mid_reg < in_alt_reg) && (in_alt_reg > 0))
                begin
                    phase_next = rfpd_pkg::PHASE_ASCENT;
                end
            end
            rfpd_pkg::PHASE_ASCENT:
            begin
                if (dropped)
                begin
                    drop_cnt_next = (drop_cnt_reg == rfpd_pkg::CNT_MAX) ?
                                    drop_cnt_reg : drop_cnt_reg + rfpd_pkg::cnt_t'(1);
                end
                else
                begin
                    drop_cnt_next = '0;
                end
                if (drop_cnt_next >= need)
                begin
                    phase_next  = rfpd_pkg::PHASE_APOGEE;
                    apogee_next = max_next;
                end
            end
            rfpd_pkg::PHASE_APOGEE:
            begin
                phase_next = rfpd_pkg::PHASE_DESCENT;
            end
            rfpd_pkg::PHASE_DESCENT:
            begin
                if (newest5_x <= apogee4_x)
                begin
                    phase_next = rfpd_pkg::PHASE_PAYLOAD;
                end
            end
            rfpd_pkg::PHASE_PAYLOAD:
            begin
                if (newest_x <= probe_x)
                begin
                    phase_next = rfpd_pkg::PHASE_PROBE;
                end
            end
            rfpd_pkg::PHASE_PROBE:
            begin
                if (in_alt_reg == '0)
                begin
                    phase_next = rfpd_pkg::PHASE_LANDED;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_old_reg   <= '0;
            win_mid_reg   <= '0;
            max_reg       <= '0;
            apogee_reg    <= '0;
            drop_cnt_reg  <= '0;
            phase_reg     <= rfpd_pkg::PHASE_PAD;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                win_old_reg   <= win_mid_reg;
                win_mid_reg   <= in_alt_reg;
                max_reg       <= max_next;
                apogee_reg    <= apogee_next;
                drop_cnt_reg  <= drop_cnt_next;
                phase_reg     <= phase_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_alt_reg <= altitude;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_margin_reg <= rfpd_pkg::DROP_MARGIN_RST;
            confirm_reg     <= rfpd_pkg::CONFIRM_COUNT_RST;
            probe_alt_reg   <= rfpd_pkg::PROBE_ALT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rfpd_pkg::CFG_DROP_MARGIN:   drop_margin_reg <= cfg_data;
                rfpd_pkg::CFG_CONFIRM_COUNT: confirm_reg     <= cfg_data[rfpd_pkg::CNT_W-1:0];
                rfpd_pkg::CFG_PROBE_ALT:     probe_alt_reg   <= cfg_data;
                default:                     drop_margin_reg <= drop_margin_reg;
            endcase
        end
    end

endmodule

@@ sv/rfpd_checker.sv @@
// Port-level checker for the flight phase detector, bound to the top level.
// Depends on rfpd_pkg and rocket_flight_phase_detector_unit_assert.svh.
`include "rocket_flight_phase_detector_unit_assert.svh"

module rfpd_checker #(
    parameter int ALT_WIDTH = 24
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input rfpd_pkg::phase_t            phase,
    input logic signed [ALT_WIDTH-1:0] apogee_altitude
);

    rfpd_pkg::phase_t            last_phase_reg;
    logic signed [ALT_WIDTH-1:0] last_apogee_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg  <= rfpd_pkg::PHASE_PAD;
            last_apogee_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_phase_reg  <= phase;
            last_apogee_reg <= apogee_altitude;
        end
    end

    `RFPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(phase) && $stable(apogee_altitude),
        "Stalled result transaction changed")
    `RFPD_ASSERT_NOW(a_phase_step, out_valid,
        (phase == last_phase_reg) || (phase == last_phase_reg + 3'd1),
        "Phase moved by more than one step")
    `RFPD_ASSERT_NOW(a_apogee_zero,
        out_valid && (phase == rfpd_pkg::PHASE_PAD || phase == rfpd_pkg::PHASE_ASCENT),
        apogee_altitude == '0, "Apogee altitude set before apogee")
    `RFPD_ASSERT_NOW(a_apogee_held,
        out_valid && (last_phase_reg >= rfpd_pkg::PHASE_DESCENT),
        apogee_altitude == last_apogee_reg, "Apogee altitude changed after apogee")

endmodule

bind rocket_flight_phase_detector_unit rfpd_checker #(
    .ALT_WIDTH (ALT_WIDTH)
) u_rfpd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .phase           (phase),
    .apogee_altitude (apogee_altitude)
);
